@@ rtl/core/bspx_pkg.sv @@
// Shared types and constants for the BMP stream parser.
// Used by the front end, the item queue, the back end and the top level.
package bspx_pkg;

   // File layout, offsets from the start of the file
   localparam logic [31:0] POS_SIG_FIRST   = 32'd0;
   localparam logic [31:0] POS_SIG_SECOND  = 32'd1;
   localparam logic [31:0] POS_RSV_FIRST   = 32'd6;
   localparam logic [31:0] POS_RSV_LAST    = 32'd9;
   localparam logic [31:0] POS_OFFSET      = 32'd10;
   localparam logic [31:0] FILE_HDR_LEN    = 32'd14;
   localparam logic [31:0] POS_DIB_LEN_END = 32'd18;
   localparam logic [31:0] POS_DIB_LEN_TOP = 32'd17;
   localparam logic [31:0] POS_WIDTH       = 32'd18;
   localparam logic [31:0] POS_HEIGHT      = 32'd22;
   localparam logic [31:0] POS_HEIGHT_END  = 32'd26;
   localparam logic [31:0] POS_DEPTH       = 32'd28;
   localparam logic [31:0] POS_DEPTH_END   = 32'd30;
   localparam logic [31:0] POS_SIZE        = 32'd34;
   localparam logic [31:0] POS_SIZE_END    = 32'd38;

   localparam logic [31:0] DIB_MIN_LEN     = 32'd24;
   localparam logic [7:0]  SIG_FIRST_BYTE  = 8'h42;
   localparam logic [7:0]  SIG_SECOND_BYTE = 8'h4D;
   localparam logic [15:0] XOR_DEPTH       = 16'h0020;

   localparam int BSPX_QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      REGION_FILE_HDR = 3'd0,
      REGION_DIB_HDR  = 3'd1,
      REGION_GAP      = 3'd2,
      REGION_PIXEL    = 3'd3,
      REGION_IGNORED  = 3'd4
   } region_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_SIGNATURE = 2'd1,
      STATUS_DIB_SHORT = 2'd2,
      STATUS_BAD_SEEK  = 2'd3
   } status_type;

   // One classified byte with a snapshot of the header fields
   typedef struct packed {
      logic [7:0]  data_byte;
      logic [7:0]  key_byte;
      logic        xor_en;
      region_type  region;
      status_type  status;
      logic [31:0] image_width;
      logic [31:0] image_height;
      logic [15:0] bits_per_pixel;
      logic [31:0] pixel_offset;
      logic [31:0] pixel_bytes;
      logic        last_data;
   } bspx_item_type;

endpackage

@@ rtl/core/bspx_front.sv @@
// Front end of the BMP stream parser: accepts bytes, tracks file position,
// captures header fields and classifies each byte. Depends on bspx_pkg.
module bspx_front
   import bspx_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write_enable,
   input  logic          csr_write_data,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [15:0]   req_tdata,
   input  logic          req_tuser,
   input  logic          q_space,
   output logic          q_push,
   output bspx_item_type q_item
);

   logic        enable_ff;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] offset_ff, offset_in;
   logic [31:0] dib_ff, dib_in;
   logic [31:0] width_ff, width_in;
   logic [31:0] height_ff, height_in;
   logic [15:0] depth_ff, depth_in;
   logic [31:0] size_ff, size_in;
   status_type  status_ff, status_in;
   logic [32:0] hdr_end_ff, hdr_end_in;
   logic [32:0] data_end_ff, data_end_in;

   logic        accept;
   logic        start;
   logic [7:0]  in_byte;
   logic [31:0] p;
   logic [32:0] p_wide;
   logic [32:0] p_plus1;
   logic [31:0] offset_cur, dib_cur, width_cur, height_cur, size_cur;
   logic [15:0] depth_cur;
   status_type  status_cur;
   logic [32:0] hdr_end_cur, data_end_cur;
   logic [1:0]  byte_idx;
   region_type  region;
   logic        xor_en;
   logic        last;

   function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [7:0] b,
                                            input logic [1:0] idx);
      put_byte = word | ({24'd0, b} << {idx, 3'b000});
   endfunction

   assign req_tready = q_space;
   assign accept     = req_tvalid & q_space;
   assign q_push     = accept;
   assign in_byte    = req_tdata[7:0];
   assign start      = req_tuser;

   // A frame start wipes the file state before this byte is handled
   assign p            = start ? 32'd0 : pos_ff;
   assign offset_cur   = start ? 32'd0 : offset_ff;
   assign dib_cur      = start ? 32'd0 : dib_ff;
   assign width_cur    = start ? 32'd0 : width_ff;
   assign height_cur   = start ? 32'd0 : height_ff;
   assign depth_cur    = start ? 16'd0 : depth_ff;
   assign size_cur     = start ? 32'd0 : size_ff;
   assign status_cur   = start ? STATUS_OK : status_ff;
   assign hdr_end_cur  = start ? {1'b0, FILE_HDR_LEN} : hdr_end_ff;
   assign data_end_cur = start ? 33'd0 : data_end_ff;

   assign p_wide   = {1'b0, p};
   assign p_plus1  = p_wide + 33'd1;
   // all four-byte fields start at an offset of 2 mod 4
   assign byte_idx = p[1:0] - 2'd2;

   always_comb begin
      offset_in = offset_cur;
      dib_in    = dib_cur;
      width_in  = width_cur;
      height_in = height_cur;
      depth_in  = depth_cur;
      size_in   = size_cur;
      status_in = status_cur;
      region    = REGION_IGNORED;
      xor_en    = 1'b0;
      last      = 1'b0;
      if (status_cur == STATUS_OK) begin
         if (p < FILE_HDR_LEN) begin
            region = REGION_FILE_HDR;
            if ((p == POS_SIG_FIRST && in_byte != SIG_FIRST_BYTE) ||
                (p == POS_SIG_SECOND && in_byte != SIG_SECOND_BYTE) ||
                (p >= POS_RSV_FIRST && p <= POS_RSV_LAST && in_byte != 8'd0)) begin
               status_in = STATUS_SIGNATURE;
            end
            if (p >= POS_OFFSET) begin
               offset_in = put_byte(offset_cur, in_byte, byte_idx);
            end
         end else if (p < POS_DIB_LEN_END) begin
            region = REGION_DIB_HDR;
            dib_in = put_byte(dib_cur, in_byte, byte_idx);
            if (p == POS_DIB_LEN_TOP && dib_in < DIB_MIN_LEN) begin
               status_in = STATUS_DIB_SHORT;
            end
         end else if (p_wide < hdr_end_cur) begin
            region = REGION_DIB_HDR;
            if (p >= POS_WIDTH && p < POS_HEIGHT) begin
               width_in = put_byte(width_cur, in_byte, byte_idx);
            end else if (p >= POS_HEIGHT && p < POS_HEIGHT_END) begin
               height_in = put_byte(height_cur, in_byte, byte_idx);
            end else if (p >= POS_DEPTH && p < POS_DEPTH_END) begin
               depth_in = depth_cur | ({8'd0, in_byte} << {p[0], 3'b000});
            end else if (p >= POS_SIZE && p < POS_SIZE_END) begin
               size_in = put_byte(size_cur, in_byte, byte_idx);
            end
            // data offset pointing back into the headers
            if (p_plus1 == hdr_end_cur && {1'b0, offset_cur} < hdr_end_cur) begin
               status_in = STATUS_BAD_SEEK;
            end
         end else if (p < offset_cur) begin
            region = REGION_GAP;
         end else if (p_wide < data_end_cur) begin
            region = REGION_PIXEL;
            xor_en = enable_ff && (depth_cur == XOR_DEPTH);
            last   = (p_plus1 == data_end_cur);
         end
      end
   end

   assign pos_in      = (p == 32'hFFFF_FFFF) ? p : p_plus1[31:0];
   assign hdr_end_in  = {1'b0, FILE_HDR_LEN} + {1'b0, dib_in};
   assign data_end_in = {1'b0, offset_in} + {1'b0, size_in};

   always_comb begin
      q_item.data_byte      = in_byte;
      q_item.key_byte       = req_tdata[15:8];
      q_item.xor_en         = xor_en;
      q_item.region         = region;
      q_item.status         = status_in;
      q_item.image_width    = width_in;
      q_item.image_height   = height_in;
      q_item.bits_per_pixel = depth_in;
      q_item.pixel_offset   = offset_in;
      q_item.pixel_bytes    = size_in;
      q_item.last_data      = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b0;
         pos_ff      <= 32'd0;
         offset_ff   <= 32'd0;
         dib_ff      <= 32'd0;
         width_ff    <= 32'd0;
         height_ff   <= 32'd0;
         depth_ff    <= 16'd0;
         size_ff     <= 32'd0;
         status_ff   <= STATUS_OK;
         hdr_end_ff  <= {1'b0, FILE_HDR_LEN};
         data_end_ff <= 33'd0;
      end else begin
         if (csr_write_enable) begin
            enable_ff <= csr_write_data;
         end
         if (accept) begin
            pos_ff      <= pos_in;
            offset_ff   <= offset_in;
            dib_ff      <= dib_in;
            width_ff    <= width_in;
            height_ff   <= height_in;
            depth_ff    <= depth_in;
            size_ff     <= size_in;
            status_ff   <= status_in;
            hdr_end_ff  <= hdr_end_in;
            data_end_ff <= data_end_in;
         end
      end
   end

endmodule

@@ rtl/core/bspx_queue.sv @@
// Short FIFO of classified items between parser front end and back end.
// Depends on bspx_pkg for the item type.
module bspx_queue
   import bspx_pkg::*;
#(
   parameter int DEPTH = BSPX_QUEUE_DEPTH
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  bspx_item_type push_item,
   output logic          space,
   input  logic          pop,
   output logic          pop_valid,
   output bspx_item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bspx_item_type    entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign space     = (count_ff != CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign do_push   = push & space;
   assign do_pop    = pop & pop_valid;

   assign wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

endmodule

@@ rtl/core/bspx_back.sv @@
// Back end of the BMP stream parser: applies the key XOR to pixel bytes and
// holds the result in the output register. Depends on bspx_pkg.
module bspx_back
   import bspx_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   input  bspx_item_type q_item,
   output logic          q_pop,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [151:0]  rsp_tdata,
   output logic [4:0]    rsp_tuser,
   output logic          rsp_tlast
);

   bspx_item_type out_ff, out_in;
   logic          valid_ff;
   logic          load;

   assign load  = !valid_ff || rsp_tready;
   assign q_pop = q_valid && load;

   always_comb begin
      out_in = q_item;
      if (q_item.xor_en) begin
         out_in.data_byte = q_item.data_byte ^ q_item.key_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= q_valid;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {out_ff.pixel_bytes, out_ff.pixel_offset, out_ff.bits_per_pixel,
                        out_ff.image_height, out_ff.image_width, out_ff.data_byte};
   assign rsp_tuser  = {out_ff.status, out_ff.region};
   assign rsp_tlast  = out_ff.last_data;

   // Only pixel bytes of a clean file are ever encrypted or marked last
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> out_ff.region == REGION_PIXEL)
      else $error("last flag outside pixel data");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_ff.region == REGION_PIXEL |-> out_ff.status == STATUS_OK)
      else $error("pixel data reported after an error");

   assert property (@(posedge clock) disable iff (reset)
      q_pop && q_item.xor_en |-> q_item.region == REGION_PIXEL)
      else $error("key applied outside pixel data");

endmodule

@@ rtl/core/bmp_stream_parse_xor_top.sv @@
// Top level of the streaming BMP header parser with pixel XOR.
// Instantiates bspx_front, bspx_queue and bspx_back; depends on bspx_pkg.
//
// Usage:
//   req_*  : one file byte per transfer. tdata = in_byte, key_byte; tuser
//            = frame_start, which restarts parsing at offset 0.
//   rsp_*  : one result per input byte, in order. tdata carries the byte
//            (XORed with the key for 32-bit pixel data when enabled) and
//            the header fields captured so far; tuser = region, status;
//            tlast flags the final pixel data byte.
//   csr_*  : write-only encrypt enable, written while the block is idle.
// Timing: each byte is registered in the queue, then in the output register
//   that drives rsp_tvalid. Sustained rate is one byte per cycle while
//   rsp_tready is high; the front end does a position compare and field
//   capture per byte, the back end an XOR, with a two-entry queue between them.
// Reset clears the enable, the file position and all captured fields;
//   the first byte after reset is taken as offset 0.
// A stalled rsp_tready holds the output register; the queue keeps taking
//   bytes until it fills, then req_tready drops.
module bmp_stream_parse_xor_top
   import bspx_pkg::*;
#(
   parameter int QUEUE_DEPTH = BSPX_QUEUE_DEPTH
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_enable,
   input  logic         csr_write_data,   // encrypt_enable
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,        // in_byte, key_byte
   input  logic         req_tuser,        // frame_start
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_byte, image_width, image_height, bits_per_pixel, pixel_offset, pixel_bytes
   output logic [151:0] rsp_tdata,
   output logic [4:0]   rsp_tuser,        // region, status
   output logic         rsp_tlast         // last_data
);

   bspx_item_type front_item;
   bspx_item_type back_item;
   logic          q_space;
   logic          q_push;
   logic          q_pop;
   logic          q_valid;

   bspx_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .q_space          (q_space),
      .q_push           (q_push),
      .q_item           (front_item)
   );

   bspx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .space     (q_space),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_item  (back_item)
   );

   bspx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (back_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
